// ----- design/smet_pkg.sv -----
// ----------------------------------------------------------------------------
// smet_pkg: shared types and constants of the sparse matrix entry table
// Entry count, dimension limits, request and status codes, cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package smet_pkg;

    localparam int ENTRIES  = 64;
    localparam int MAX_DIM  = 4096;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 12;
    localparam int DIM_W    = 13;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // register index as seen on paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_COMMIT
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic                    commit;
        logic                    upd;
        logic                    del;
        logic                    ins;
        logic                    resize;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic [DIM_W-1:0]        nr;
        logic [DIM_W-1:0]        nc;
    } t_cmd;

    // passed from cell to cell
    typedef struct packed {
        logic                    free_seen;
        logic                    hit_seen;
        logic signed [VAL_W-1:0] hit_value;
    } t_link;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic at_least_one);
        logic [DIM_W-1:0] res;
        res = v;
        if (32'(v) > 32'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        if (at_least_one && (res == '0)) begin
            res = DIM_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/smet_cell.sv -----
// ----------------------------------------------------------------------------
// smet_cell: one entry of the table
// Holds row, column, value and valid; compares its key every cycle and
// extends the hit and free-slot link toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module smet_cell
    import smet_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_link i_link,
    output t_link      o_link
);

    logic                    r_valid;
    logic                    r_hit;
    logic [IDX_W-1:0]        r_row;
    logic [IDX_W-1:0]        r_col;
    logic signed [VAL_W-1:0] r_value;

    logic w_grant;
    logic w_outside;

    // lowest free cell takes an insert
    assign w_grant   = !r_valid && !i_link.free_seen;
    assign w_outside = ({1'b0, r_row} >= i_cmd.nr) || ({1'b0, r_col} >= i_cmd.nc);

    always_comb begin
        o_link.free_seen = i_link.free_seen || !r_valid;
        o_link.hit_seen  = i_link.hit_seen || r_hit;
        o_link.hit_value = i_link.hit_value | (r_hit ? r_value : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_hit <= r_valid && (r_row == i_cmd.row) && (r_col == i_cmd.col);
            if (i_cmd.commit) begin
                if (i_cmd.del && r_hit) begin
                    r_valid <= 1'b0;
                end
                if (i_cmd.ins && w_grant) begin
                    r_valid <= 1'b1;
                end
                if (i_cmd.resize && r_valid && w_outside) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (i_cmd.upd && r_hit) begin
                r_value <= i_cmd.value;
            end
            if (i_cmd.ins && w_grant) begin
                r_row   <= i_cmd.row;
                r_col   <= i_cmd.col;
                r_value <= i_cmd.value;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/smet_chain.sv -----
// ----------------------------------------------------------------------------
// smet_chain: row of entry cells
// Broadcasts the command to all cells and links them head to tail.
// ----------------------------------------------------------------------------
`default_nettype none

module smet_chain
    import smet_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    output t_link      o_link
);

    t_link w_link [ENTRIES+1];

    assign w_link[0] = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        smet_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (i_cmd),
            .i_link (w_link[k]),
            .o_link (w_link[k+1])
        );
    end

    assign o_link = w_link[ENTRIES];

endmodule

`default_nettype wire

// ----- design/sparse_matrix_entry_table.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_entry_table: sparse matrix kept as a table of nonzero entries
// Read, write and resize requests over a chain of entry cells.
// ----------------------------------------------------------------------------
// Each item has a match cycle in which every cell compares its stored
// position with the request, then a commit cycle in which the cell
// chain yields the hit value and the lowest free cell and the table is
// updated. The next item is taken in that commit cycle; a result left
// waiting at the output holds the commit until it is taken. The table
// is empty right after reset, with no clearing pass. Dimension registers
// sit at byte 0 (rows) and 4 (cols).
`default_nettype none

module sparse_matrix_entry_table
    import smet_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_col,
    input  wire logic signed [VAL_W-1:0]  i_value,
    input  wire logic [DIM_W-1:0]         i_new_rows,
    input  wire logic [DIM_W-1:0]         i_new_cols,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [VAL_W-1:0]       o_data,
    output logic [STAT_W-1:0]             o_status
);

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_init_rows, r_init_cols;
    logic [DIM_W-1:0] r_row_count, r_col_count;

    logic [MODE_W-1:0]        r_req_mode;
    logic [IDX_W-1:0]         r_req_row, r_req_col;
    logic signed [VAL_W-1:0]  r_req_value;
    logic [DIM_W-1:0]         r_req_nr, r_req_nc;

    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_data, n_data;
    logic [STAT_W-1:0]        r_status, n_status;

    logic  w_commit;
    logic  w_in_xfer;
    logic  w_cfg_wr;
    logic  w_range_bad;
    t_cmd  w_cmd;
    t_link w_link;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_in_xfer = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = DATA_W'(r_init_rows);
            REG_COLS: prdata = DATA_W'(r_init_cols);
            default:  prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MATCH;
            S_MATCH:  n_state = S_COMMIT;
            S_COMMIT: if (w_commit) n_state = i_in_valid ? S_MATCH : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        w_commit   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_MATCH: o_in_stall = 1'b1;
            S_COMMIT: begin
                w_commit   = !r_out_valid || !i_out_stall;
                o_in_stall = !w_commit;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_range_bad = ({1'b0, r_req_row} >= r_row_count) ||
                         ({1'b0, r_req_col} >= r_col_count);

    always_comb begin
        w_cmd        = '0;
        w_cmd.commit = w_commit;
        w_cmd.row    = r_req_row;
        w_cmd.col    = r_req_col;
        w_cmd.value  = r_req_value;
        w_cmd.nr     = clamp_dim(r_req_nr, 1'b0);
        w_cmd.nc     = clamp_dim(r_req_nc, 1'b0);
        n_data       = '0;
        n_status     = STATUS_OK;
        unique case (r_req_mode)
            MODE_READ: begin
                if (w_range_bad) begin
                    n_status = STATUS_RANGE;
                end else begin
                    n_data = w_link.hit_value;
                end
            end
            MODE_WRITE: begin
                if (w_range_bad) begin
                    n_status = STATUS_RANGE;
                end else if (w_link.hit_seen) begin
                    n_data    = w_link.hit_value;
                    w_cmd.upd = (r_req_value != '0);
                    w_cmd.del = (r_req_value == '0);
                end else if (r_req_value != '0) begin
                    if (w_link.free_seen) begin
                        w_cmd.ins = 1'b1;
                    end else begin
                        n_status = STATUS_FULL;
                    end
                end
            end
            MODE_RESIZE: w_cmd.resize = 1'b1;
            default: n_status = STATUS_OK;
        endcase
    end

    smet_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_link (w_link)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_init_rows <= DIM_RESET;
            r_init_cols <= DIM_RESET;
            r_row_count <= clamp_dim(DIM_RESET, 1'b1);
            r_col_count <= clamp_dim(DIM_RESET, 1'b1);
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && w_cmd.resize) begin
                r_row_count <= w_cmd.nr;
                r_col_count <= w_cmd.nc;
            end
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_ROWS: begin
                        r_init_rows <= pwdata[DIM_W-1:0];
                        r_row_count <= clamp_dim(pwdata[DIM_W-1:0], 1'b1);
                    end
                    REG_COLS: begin
                        r_init_cols <= pwdata[DIM_W-1:0];
                        r_col_count <= clamp_dim(pwdata[DIM_W-1:0], 1'b1);
                    end
                    default: r_init_rows <= r_init_rows;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_mode  <= i_mode;
            r_req_row   <= i_row;
            r_req_col   <= i_col;
            r_req_value <= i_value;
            r_req_nr    <= i_new_rows;
            r_req_nc    <= i_new_cols;
        end
        if (w_commit) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ----- design/smet_checker.sv -----
// ----------------------------------------------------------------------------
// smet_checker: port-level checks of the sparse matrix entry table
// Output handshake rules, one item in flight, result code consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module smet_checker
    import smet_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic signed [VAL_W-1:0]  o_data,
    input wire logic [STAT_W-1:0]        o_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_data) && $stable(o_status))
        else $error("stalled result changed");

    // match cycle follows every accepted transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken in match cycle");

    // flagged results carry zero data, and no unused status code
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK) ||
                        ((o_data == '0) &&
                         ((o_status == STATUS_RANGE) || (o_status == STATUS_FULL))))
        else $error("bad status or data on flagged result");

endmodule

bind sparse_matrix_entry_table smet_checker u_smet_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_data     (o_data),
    .o_status   (o_status)
);

`default_nettype wire
